/* hw/rtl/tlce_pkg.sv */
// Shared types, register indexes and helpers for the three-line chorus ensemble.
package tlce_pkg;

    localparam int LINE_COUNT = 3;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 40;
    localparam int MUL_BW = 19;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [16:0] UNITY_Q16      = 17'd65536;
    localparam logic [17:0] TWO_THIRDS_Q16 = 18'd43691;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_SLOW_STEP  = 3'd1;
    localparam logic [2:0] REG_FAST_STEP  = 3'd2;
    localparam logic [2:0] REG_TREM_DEPTH = 3'd3;
    localparam logic [2:0] REG_CHOR_DEPTH = 3'd4;
    localparam logic [2:0] REG_WIDTH      = 3'd5;
    localparam logic [2:0] REG_CENTRE     = 3'd6;
    localparam logic [2:0] REG_SWING      = 3'd7;

    typedef struct packed {
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } mul_req_t;

    function automatic logic signed [15:0] sat16(input logic signed [MUL_PW-1:0] v);
        logic signed [15:0] r;
        if (v > $signed(MUL_PW'(32767)))
            r = 16'sd32767;
        else if (v < $signed(-MUL_PW'(32768)))
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* hw/rtl/tlce_mul.sv */
// Shared signed multiplier with a registered product.
module tlce_mul
    import tlce_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [MUL_PW-1:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= req.a * req.b;
    end

endmodule

/* hw/rtl/three_line_chorus_ensemble.sv */
// Top level of the three-line chorus ensemble: sequencer, delay memory, sine ROM, outputs.
// One sample beat is worked through by a sequencer around a single shared multiplier:
// for each line a sample write, two sine lookups with interpolation and depth weighting,
// delay computation, four tap reads from the single-port delay memory and cubic evaluation,
// then the stereo mix; s_tready is low meanwhile.
// A finished result waits in the output register while the next beat is taken.
// After reset a clearing pass zeroes the delay memory, all LINE_COUNT*LINE_LENGTH words
// (3072 by default), before the first beat is accepted; configuration writes belong between
// beats, while no beat is being worked on.
module three_line_chorus_ensemble
    import tlce_pkg::*;
#(
    parameter int LINE_LENGTH     = 1024,
    parameter int SINE_TABLE_SIZE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // raw_sample[15:0], filtered_sample[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_mix[15:0], right_mix[31:16]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW   = $clog2(LINE_LENGTH);
    localparam int MAW  = $clog2(LINE_COUNT * LINE_LENGTH);
    localparam int IDXW = $clog2(SINE_TABLE_SIZE + 1);
    localparam int DW   = AW + 16;
    localparam int RPW  = DW + 2;
    localparam logic [MAW-1:0] CLR_LAST = MAW'(LINE_COUNT * LINE_LENGTH - 1);
    localparam logic [MAW-1:0] LEN_M    = MAW'(LINE_LENGTH);
    localparam logic [AW-1:0]  LAST_IX  = AW'(LINE_LENGTH - 1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CLR  = 5'd1;
    localparam logic [4:0] ST_WR   = 5'd2;
    localparam logic [4:0] ST_OP   = 5'd3;
    localparam logic [4:0] ST_OI   = 5'd4;
    localparam logic [4:0] ST_RA   = 5'd5;
    localparam logic [4:0] ST_RB   = 5'd6;
    localparam logic [4:0] ST_RC   = 5'd7;
    localparam logic [4:0] ST_RD   = 5'd8;
    localparam logic [4:0] ST_RE   = 5'd9;
    localparam logic [4:0] ST_DM   = 5'd10;
    localparam logic [4:0] ST_DL   = 5'd11;
    localparam logic [4:0] ST_RP   = 5'd12;
    localparam logic [4:0] ST_TAP  = 5'd13;
    localparam logic [4:0] ST_CF   = 5'd14;
    localparam logic [4:0] ST_C1   = 5'd15;
    localparam logic [4:0] ST_C2   = 5'd16;
    localparam logic [4:0] ST_C3   = 5'd17;
    localparam logic [4:0] ST_C4   = 5'd18;
    localparam logic [4:0] ST_M1   = 5'd19;
    localparam logic [4:0] ST_M2   = 5'd20;
    localparam logic [4:0] ST_M3   = 5'd21;

    typedef logic signed [15:0] sine_rom_t [0:SINE_TABLE_SIZE];

    // quarter-wave polynomial, every product truncated by 15 bits
    function automatic sine_rom_t build_sine();
        sine_rom_t         r;
        logic [63:0]       p64;
        logic [31:0]       p;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        for (int k = 0; k <= SINE_TABLE_SIZE; k++)
        begin
            p64 = (64'(k) << 32) / SINE_TABLE_SIZE;
            p   = p64[31:0];
            x   = 64'(p[29:15]);
            if (p[30])
                x = 64'd32768 - x;
            x2 = (x * x) >> 15;
            t  = (64'd2611 * x2) >> 15;
            t  = 64'd21167 - t;
            t  = (t * x2) >> 15;
            t  = 64'd51472 - t;
            t  = (t * x) >> 15;
            if (t > 64'd32767)
                t = 64'd32767;
            r[k] = p[31] ? -$signed(t[15:0]) : $signed(t[15:0]);
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    // configuration
    logic        enable_reg;
    logic [23:0] slow_step_reg;
    logic [23:0] fast_step_reg;
    logic [16:0] trem_depth_reg;
    logic [16:0] chor_depth_reg;
    logic [16:0] width_reg;
    logic [17:0] centre_reg;
    logic [17:0] swing_reg;

    // control
    logic [4:0]     state_reg;
    logic [MAW-1:0] clr_reg;
    logic [1:0]     line_reg;
    logic           osc_reg;
    logic [2:0]     tap_reg;
    logic [AW-1:0]  wi_reg;
    logic [MAW-1:0] base_reg;
    logic [AW-1:0]  ti_reg;
    logic [31:0]    slow_ph_reg [LINE_COUNT];
    logic [31:0]    fast_ph_reg [LINE_COUNT];
    logic           out_valid_reg;

    // datapath
    logic signed [15:0]       raw_reg;
    logic signed [15:0]       filt_reg;
    logic [IDXW-1:0]          idx_reg;
    logic [15:0]              frac_reg;
    logic signed [15:0]       a_reg;
    logic signed [35:0]       mod_reg;
    logic [DW-1:0]            delay_reg;
    logic [15:0]              mu_reg;
    logic signed [15:0]       y_reg [4];
    logic signed [19:0]       ca_reg;
    logic signed [20:0]       cb_reg;
    logic signed [16:0]       cc_reg;
    logic signed [21:0]       d_reg [LINE_COUNT];
    logic signed [MUL_PW-1:0] mid_reg;
    logic signed [15:0]       left_reg;
    logic signed [15:0]       right_reg;

    logic signed [15:0]       rom_q;
    logic [IDXW-1:0]          rom_addr;
    logic [15:0]              mem_q;
    logic [MAW-1:0]           mem_addr;
    logic                     mem_we;
    logic [15:0]              mem_wdata;
    logic [15:0]              line_mem [LINE_COUNT * LINE_LENGTH];

    mul_req_t                 mreq;
    logic signed [MUL_PW-1:0] prod;

    logic [AW-1:0]            wi_n;
    logic [AW-1:0]            ti_inc;
    logic [16:0]              td;
    logic [16:0]              cd;
    logic [16:0]              wd;
    logic [31:0]              phase_sel;
    logic [16:0]              depth_sel;
    logic signed [16:0]       dif;
    logic signed [16:0]       sval;
    logic signed [MUL_PW-1:0] t1;
    logic signed [MUL_PW-1:0] t2;
    logic signed [39:0]       dl;
    logic signed [RPW-1:0]    rp;
    logic signed [RPW-1:0]    rpw;
    logic [AW-1:0]            i1;
    logic signed [23:0]       dsum;
    logic signed [22:0]       ddif;
    logic signed [MUL_PW-1:0] lsum;
    logic signed [MUL_PW-1:0] rsum;
    logic                     out_load;

    tlce_mul u_mul
    (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    assign wi_n   = (wi_reg == LAST_IX) ? '0 : wi_reg + 1'b1;
    assign ti_inc = (ti_reg == LAST_IX) ? '0 : ti_reg + 1'b1;
    assign td     = (trem_depth_reg > UNITY_Q16) ? UNITY_Q16 : trem_depth_reg;
    assign cd     = (chor_depth_reg > UNITY_Q16) ? UNITY_Q16 : chor_depth_reg;
    assign wd     = (width_reg > UNITY_Q16) ? UNITY_Q16 : width_reg;
    assign phase_sel = osc_reg ? fast_ph_reg[line_reg] : slow_ph_reg[line_reg];
    assign depth_sel = osc_reg ? cd : td;
    assign dif    = 17'(rom_q) - 17'(a_reg);
    assign sval   = 17'(a_reg) + 17'(prod >>> 16);
    assign t1     = prod + (MUL_PW'(cb_reg) <<< 16);
    assign t2     = (prod >>> 16) + (MUL_PW'(cc_reg) <<< 16);
    assign dl     = $signed({14'b0, centre_reg, 8'b0}) + 40'(prod >>> 23);
    assign rp     = $signed({1'b0, wi_n, 16'b0}) - $signed({2'b0, delay_reg});
    assign rpw    = rp[RPW-1] ? rp + $signed(RPW'(LINE_LENGTH) <<< 16) : rp;
    assign i1     = rpw[16 +: AW];
    assign dsum   = 24'(d_reg[0]) + 24'(d_reg[1]) + 24'(d_reg[2]);
    assign ddif   = 23'(d_reg[0]) - 23'(d_reg[2]);
    assign lsum   = (mid_reg + prod) >>> 16;
    assign rsum   = (mid_reg - prod) >>> 16;
    assign out_load = (state_reg == ST_M3) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_reg, left_reg};

    // multiplier operand select
    always_comb
    begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            ST_OP:
            begin
                mreq.a = $signed({8'b0, phase_sel});
                mreq.b = $signed(MUL_BW'(SINE_TABLE_SIZE));
            end
            ST_RC:
            begin
                mreq.a = MUL_AW'(dif);
                mreq.b = $signed({3'b0, frac_reg});
            end
            ST_RD:
            begin
                mreq.a = MUL_AW'(sval);
                mreq.b = $signed({2'b0, depth_sel});
            end
            ST_DM:
            begin
                mreq.a = MUL_AW'(mod_reg);
                mreq.b = $signed({1'b0, swing_reg});
            end
            ST_C1:
            begin
                mreq.a = MUL_AW'(ca_reg);
                mreq.b = $signed({3'b0, mu_reg});
            end
            ST_C2:
            begin
                mreq.a = $signed(t1[MUL_AW-1:0]);
                mreq.b = $signed({3'b0, mu_reg});
            end
            ST_C3:
            begin
                mreq.a = $signed(t2[MUL_AW-1:0]);
                mreq.b = $signed({3'b0, mu_reg});
            end
            ST_M1:
            begin
                mreq.a = MUL_AW'(dsum);
                mreq.b = $signed({1'b0, TWO_THIRDS_Q16});
            end
            // side product is reissued while the result waits
            ST_M2, ST_M3:
            begin
                mreq.a = MUL_AW'(ddif);
                mreq.b = $signed({2'b0, wd});
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // memory address and write select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = filt_reg;
        case (state_reg)
            ST_CLR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_WR:
            begin
                mem_addr = base_reg + MAW'(wi_reg);
                mem_we   = 1'b1;
            end
            default:
            begin
                mem_addr = base_reg + MAW'(ti_reg);
            end
        endcase
    end

    assign rom_addr = (state_reg == ST_RA) ? idx_reg : idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_addr] <= mem_wdata;
        mem_q <= line_mem[mem_addr];
        rom_q <= SINE_ROM[rom_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            slow_step_reg  <= 24'd521653;
            fast_step_reg  <= 24'd51899;
            trem_depth_reg <= '0;
            chor_depth_reg <= '0;
            width_reg      <= '0;
            centre_reg     <= 18'd256;
            swing_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_SLOW_STEP:  slow_step_reg  <= cfg_data;
                REG_FAST_STEP:  fast_step_reg  <= cfg_data;
                REG_TREM_DEPTH: trem_depth_reg <= cfg_data[16:0];
                REG_CHOR_DEPTH: chor_depth_reg <= cfg_data[16:0];
                REG_WIDTH:      width_reg      <= cfg_data[16:0];
                REG_CENTRE:     centre_reg     <= cfg_data[17:0];
                REG_SWING:      swing_reg      <= cfg_data[17:0];
                default:        ;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_reg        <= '0;
            line_reg       <= '0;
            osc_reg        <= 1'b0;
            tap_reg        <= '0;
            wi_reg         <= '0;
            base_reg       <= '0;
            ti_reg         <= '0;
            slow_ph_reg[0] <= 32'h0000_0000;
            slow_ph_reg[1] <= 32'h5555_5555;
            slow_ph_reg[2] <= 32'hAAAA_AAAA;
            fast_ph_reg[0] <= 32'h0000_0000;
            fast_ph_reg[1] <= 32'h5555_5555;
            fast_ph_reg[2] <= 32'hAAAA_AAAA;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_LAST)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        line_reg  <= '0;
                        osc_reg   <= 1'b0;
                        base_reg  <= '0;
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: state_reg <= ST_OP;
                ST_OP: state_reg <= ST_OI;
                ST_OI: state_reg <= ST_RA;
                ST_RA: state_reg <= ST_RB;
                ST_RB: state_reg <= ST_RC;
                ST_RC: state_reg <= ST_RD;
                ST_RD: state_reg <= ST_RE;
                ST_RE:
                begin
                    osc_reg   <= 1'b1;
                    state_reg <= osc_reg ? ST_DM : ST_OP;
                end
                ST_DM: state_reg <= ST_DL;
                ST_DL: state_reg <= ST_RP;
                ST_RP:
                begin
                    ti_reg    <= (i1 == '0) ? LAST_IX : i1 - 1'b1;
                    tap_reg   <= '0;
                    state_reg <= ST_TAP;
                end
                ST_TAP:
                begin
                    ti_reg  <= ti_inc;
                    tap_reg <= tap_reg + 1'b1;
                    if (tap_reg == 3'd4)
                        state_reg <= ST_CF;
                end
                ST_CF: state_reg <= ST_C1;
                ST_C1: state_reg <= ST_C2;
                ST_C2: state_reg <= ST_C3;
                ST_C3: state_reg <= ST_C4;
                ST_C4:
                begin
                    slow_ph_reg[line_reg] <= slow_ph_reg[line_reg] + {8'b0, slow_step_reg};
                    fast_ph_reg[line_reg] <= fast_ph_reg[line_reg] + {8'b0, fast_step_reg};
                    base_reg <= base_reg + LEN_M;
                    osc_reg  <= 1'b0;
                    if (line_reg == 2'd2)
                        state_reg <= ST_M1;
                    else
                    begin
                        line_reg  <= line_reg + 1'b1;
                        state_reg <= ST_WR;
                    end
                end
                ST_M1: state_reg <= ST_M2;
                ST_M2: state_reg <= ST_M3;
                ST_M3:
                begin
                    // hold the side product until the output register frees up
                    if (out_load)
                    begin
                        wi_reg    <= wi_n;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                raw_reg  <= s_tdata[15:0];
                filt_reg <= s_tdata[31:16];
            end
            ST_OI:
            begin
                idx_reg  <= prod[32 +: IDXW];
                frac_reg <= prod[31:16];
            end
            ST_RB: a_reg <= rom_q;
            ST_RE:
            begin
                if (osc_reg)
                    mod_reg <= mod_reg + 36'(prod);
                else
                    mod_reg <= 36'(prod);
            end
            ST_DL:
            begin
                if (dl < 40'sd65536)
                    delay_reg <= DW'(65536);
                else if (dl > $signed(40'(LINE_LENGTH - 2) <<< 16))
                    delay_reg <= DW'(LINE_LENGTH - 2) << 16;
                else
                    delay_reg <= dl[DW-1:0];
            end
            ST_RP: mu_reg <= rpw[15:0];
            ST_TAP:
            begin
                if (tap_reg != 3'd0)
                    y_reg[tap_reg[1:0] - 2'd1] <= mem_q;
            end
            ST_CF:
            begin
                ca_reg <= 20'((20'(y_reg[3]) - 20'(y_reg[0]))
                         + 3 * (20'(y_reg[1]) - 20'(y_reg[2])));
                cb_reg <= 21'(2 * 21'(y_reg[0]) - 5 * 21'(y_reg[1])
                         + 4 * 21'(y_reg[2]) - 21'(y_reg[3]));
                cc_reg <= 17'(y_reg[2]) - 17'(y_reg[0]);
            end
            ST_C4: d_reg[line_reg] <= 22'(y_reg[1]) + 22'(prod >>> 33);
            ST_M2: mid_reg <= prod;
            ST_M3:
            begin
                if (out_load)
                begin
                    if (enable_reg)
                    begin
                        left_reg  <= sat16(lsum);
                        right_reg <= sat16(rsum);
                    end
                    else
                    begin
                        left_reg  <= raw_reg;
                        right_reg <= raw_reg;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
